FILE: rtl/price_level_order_book_assert.svh
// assertion helpers for the order book, clocked on clk and held off during reset
`ifndef PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH

// consequent checked in the same cycle
`define PLOB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLOB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/plob_pkg.sv
package plob_pkg;

	localparam int PLOB_LEVELS         = 64;
	localparam int PLOB_SNAPSHOT_DEPTH = 10;
	localparam int QUEUE_DEPTH         = 4;

	localparam logic [2:0] CMD_ADD      = 3'd0;
	localparam logic [2:0] CMD_DELETE   = 3'd1;
	localparam logic [2:0] CMD_MODIFY   = 3'd2;
	localparam logic [2:0] CMD_TRADE    = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;
	localparam logic [2:0] CMD_SNAPSHOT = 3'd5;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_DEL,
		OP_TRADE,
		OP_CLEAR,
		OP_SNAP
	} op_t;

	// one unit of work for the back end
	typedef struct packed {
		op_t         op;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} req_t;

endpackage

FILE: rtl/plob_front.sv
module plob_front
	import plob_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] repl_price,
	input  logic [31:0] new_quantity,
	output logic        q_valid,
	input  logic        q_ready,
	output req_t        q_req
);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	req_t             q_mem [QUEUE_DEPTH];
	logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             hold_v_q;
	req_t             hold_q;

	logic             not_full, accept, push, pop, hold_push, hold_set;
	req_t             push_req, hold_req;

	assign not_full  = cnt_q != QCW'(QUEUE_DEPTH);
	assign in_ready  = !hold_v_q && not_full;
	assign accept    = in_valid && in_ready;
	assign hold_push = hold_v_q && not_full;
	assign q_valid   = cnt_q != '0;
	assign q_req     = q_mem[rd_ptr_q];
	assign pop       = q_valid && q_ready;

	// classify the incoming request; modify splits into delete then add (the add only with a nonzero new quantity)
	always_comb begin
		push     = 1'b0;
		hold_set = 1'b0;
		push_req = '{op: OP_ADD, side: side, price: price, qty: quantity};
		hold_req = '{op: OP_ADD, side: side, price: repl_price, qty: new_quantity};
		if (hold_push) begin
			push     = 1'b1;
			push_req = hold_q;
		end else if (accept) begin
			unique case (command)
				CMD_ADD: begin
					push = quantity != '0;
				end
				CMD_DELETE: begin
					push        = quantity != '0;
					push_req.op = OP_DEL;
				end
				CMD_MODIFY: begin
					push        = quantity != '0;
					push_req.op = OP_DEL;
					hold_set    = new_quantity != '0;
				end
				CMD_TRADE: begin
					push        = quantity != '0;
					push_req.op = OP_TRADE;
				end
				CMD_CLEAR: begin
					push        = 1'b1;
					push_req.op = OP_CLEAR;
				end
				CMD_SNAPSHOT: begin
					push        = 1'b1;
					push_req.op = OP_SNAP;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (hold_push) begin
				hold_v_q <= 1'b0;
			end else if (hold_set) begin
				hold_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_req;
		end
		if (hold_set) begin
			hold_q <= hold_req;
		end
	end

endmodule

FILE: rtl/plob_back.sv
module plob_back
	import plob_pkg::*;
#(
	parameter int LEVELS         = PLOB_LEVELS,
	parameter int SNAPSHOT_DEPTH = PLOB_SNAPSHOT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  req_t        q_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        book_side,
	output logic [3:0]  level_index,
	output logic [31:0] level_price,
	output logic [47:0] level_size,
	output logic [15:0] order_count,
	output logic        overflow,
	output logic        last
);

	localparam int LW = $clog2(LEVELS);
	localparam int CW = $clog2(LEVELS + 1);
	localparam int AW = LW + 1;
	localparam int RW = (SNAPSHOT_DEPTH > 1) ? $clog2(SNAPSHOT_DEPTH) : 1;

	typedef struct packed {
		logic [31:0] price;
		logic [47:0] size;
		logic [15:0] count;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AD_RD, ST_AD_EV, ST_AD_INS, ST_SH_RD, ST_SH_WR, ST_DL_RD, ST_DL_EV,
		ST_RM_RD, ST_RM_WR, ST_TR_RD, ST_TR_EV, ST_SN_RD, ST_SN_EV
	} state_t;

	row_t            mem [2**AW];
	row_t            rd_q;
	state_t          state_q;
	op_t             op_q;
	logic            tside_q;
	logic [31:0]     price_q;
	logic [31:0]     rem_q;
	logic [CW-1:0]   idx_q, mv_q, ntot_q, bid_tot_q, ask_tot_q;
	logic [RW-1:0]   r_q;
	logic            flag_q;

	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	row_t            wr_data;

	logic [CW-1:0]   tot, mv_dec;
	logic            price_eq, ahead, del_gone, trade_ok, snap_have, out_free;
	logic [48:0]     sum;
	logic [47:0]     size_add, size_sub, tr_size;
	logic [15:0]     cnt_inc, cnt_dec;
	logic [31:0]     take;

	assign tot       = tside_q ? ask_tot_q : bid_tot_q;
	assign mv_dec    = mv_q - 1'b1;
	assign price_eq  = rd_q.price == price_q;
	assign ahead     = tside_q ? (rd_q.price < price_q) : (rd_q.price > price_q);
	assign sum       = {1'b0, rd_q.size} + 49'(rem_q);
	assign size_add  = sum[48] ? '1 : sum[47:0];
	assign cnt_inc   = (&rd_q.count) ? rd_q.count : rd_q.count + 1'b1;
	assign cnt_dec   = (rd_q.count == '0) ? '0 : rd_q.count - 1'b1;
	assign del_gone  = rd_q.size <= 48'(rem_q);
	assign size_sub  = rd_q.size - 48'(rem_q);
	// bids are hit at or above the limit, asks at or below
	assign trade_ok  = tside_q ? (rd_q.price <= price_q) : (rd_q.price >= price_q);
	assign take      = (48'(rem_q) < rd_q.size) ? rem_q : rd_q.size[31:0];
	assign tr_size   = rd_q.size - 48'(take);
	assign snap_have = 32'(r_q) < 32'(tot);
	assign out_free  = !out_valid || out_ready;
	assign q_ready   = state_q == ST_IDLE;

	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		rd_addr = {tside_q, idx_q[LW-1:0]};
		wr_addr = {tside_q, idx_q[LW-1:0]};
		wr_data = rd_q;
		unique case (state_q)
			ST_AD_RD, ST_DL_RD: begin
				rd_en = idx_q < tot;
			end
			ST_TR_RD: begin
				rd_en = (idx_q < tot) && (rem_q != '0);
			end
			ST_AD_EV: begin
				wr_en   = price_eq;
				wr_data = '{price: rd_q.price, size: size_add, count: cnt_inc};
			end
			ST_SH_RD: begin
				if (mv_q == idx_q) begin
					wr_en   = 1'b1;
					wr_data = '{price: price_q, size: 48'(rem_q), count: 16'd1};
				end else begin
					rd_en   = 1'b1;
					rd_addr = {tside_q, mv_dec[LW-1:0]};
				end
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = {tside_q, mv_q[LW-1:0]};
			end
			ST_DL_EV: begin
				wr_en   = price_eq && !del_gone;
				wr_data = '{price: rd_q.price, size: size_sub, count: cnt_dec};
			end
			ST_RM_RD: begin
				rd_en   = mv_q < tot;
				rd_addr = {tside_q, mv_q[LW-1:0]};
			end
			ST_RM_WR: begin
				wr_en   = 1'b1;
				wr_addr = {tside_q, mv_dec[LW-1:0]};
			end
			ST_TR_EV: begin
				wr_en   = trade_ok && (tr_size != '0);
				wr_data = '{price: rd_q.price, size: tr_size, count: cnt_dec};
			end
			ST_SN_RD: begin
				rd_en   = 1'b1;
				rd_addr = {tside_q, LW'(r_q)};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bid_tot_q   <= '0;
			ask_tot_q   <= '0;
			flag_q      <= 1'b0;
			out_valid   <= 1'b0;
			op_q        <= OP_ADD;
			tside_q     <= 1'b0;
			price_q     <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			mv_q        <= '0;
			ntot_q      <= '0;
			r_q         <= '0;
			book_side   <= 1'b0;
			level_index <= '0;
			level_price <= '0;
			level_size  <= '0;
			order_count <= '0;
			overflow    <= 1'b0;
			last        <= 1'b0;
		end else begin
			// the snapshot state sets out_valid itself
			if (out_ready && (state_q != ST_SN_EV)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q    <= q_req.op;
						tside_q <= (q_req.op == OP_TRADE) ? !q_req.side :
							(q_req.op == OP_SNAP) ? 1'b0 : q_req.side;
						price_q <= q_req.price;
						rem_q   <= q_req.qty;
						idx_q   <= '0;
						r_q     <= '0;
						unique case (q_req.op)
							OP_ADD:   state_q <= ST_AD_RD;
							OP_DEL:   state_q <= ST_DL_RD;
							OP_TRADE: state_q <= ST_TR_RD;
							OP_SNAP:  state_q <= ST_SN_RD;
							default: begin
								bid_tot_q <= '0;
								ask_tot_q <= '0;
							end
						endcase
					end
				end
				ST_AD_RD: begin
					state_q <= (idx_q < tot) ? ST_AD_EV : ST_AD_INS;
				end
				ST_AD_EV: begin
					if (ahead) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_AD_RD;
					end else if (price_eq) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_AD_INS;
					end
				end
				ST_AD_INS: begin
					// a full table loses its worst level, possibly the new one
					if (tot >= CW'(LEVELS)) begin
						flag_q <= 1'b1;
						mv_q   <= CW'(LEVELS - 1);
						ntot_q <= CW'(LEVELS);
						state_q <= (idx_q >= CW'(LEVELS)) ? ST_IDLE : ST_SH_RD;
					end else begin
						mv_q    <= tot;
						ntot_q  <= tot + 1'b1;
						state_q <= ST_SH_RD;
					end
				end
				ST_SH_RD: begin
					if (mv_q == idx_q) begin
						if (tside_q) ask_tot_q <= ntot_q;
						else bid_tot_q <= ntot_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SH_WR;
					end
				end
				ST_SH_WR: begin
					mv_q    <= mv_dec;
					state_q <= ST_SH_RD;
				end
				ST_DL_RD: begin
					state_q <= (idx_q < tot) ? ST_DL_EV : ST_IDLE;
				end
				ST_DL_EV: begin
					if (!price_eq) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_DL_RD;
					end else if (del_gone) begin
						mv_q    <= idx_q + 1'b1;
						state_q <= ST_RM_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RM_RD: begin
					if (mv_q >= tot) begin
						if (tside_q) ask_tot_q <= tot - 1'b1;
						else bid_tot_q <= tot - 1'b1;
						state_q <= (op_q == OP_TRADE) ? ST_TR_RD : ST_IDLE;
					end else begin
						state_q <= ST_RM_WR;
					end
				end
				ST_RM_WR: begin
					mv_q    <= mv_q + 1'b1;
					state_q <= ST_RM_RD;
				end
				ST_TR_RD: begin
					state_q <= ((idx_q < tot) && (rem_q != '0)) ? ST_TR_EV : ST_IDLE;
				end
				ST_TR_EV: begin
					if (!trade_ok) begin
						state_q <= ST_IDLE;
					end else begin
						rem_q <= rem_q - take;
						if (tr_size == '0) begin
							mv_q    <= idx_q + 1'b1;
							state_q <= ST_RM_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_TR_RD;
						end
					end
				end
				ST_SN_RD: begin
					state_q <= ST_SN_EV;
				end
				ST_SN_EV: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						book_side   <= tside_q;
						level_index <= 4'(r_q);
						level_price <= snap_have ? rd_q.price : '0;
						level_size  <= snap_have ? rd_q.size : '0;
						order_count <= snap_have ? rd_q.count : '0;
						overflow    <= flag_q;
						last        <= tside_q && (r_q == RW'(SNAPSHOT_DEPTH - 1));
						if (r_q == RW'(SNAPSHOT_DEPTH - 1)) begin
							r_q     <= '0;
							tside_q <= 1'b1;
							state_q <= tside_q ? ST_IDLE : ST_SN_RD;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_SN_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/price_level_order_book.sv
// price level order book: bid and ask tables of up to LEVELS levels each
// input channel: in_valid/in_ready carries one request (command, side, price,
//   quantity, repl_price, new_quantity); it is taken into a four-entry queue
// a modify is split into a delete and an add; with a nonzero new size it holds
//   in_ready low until the add is queued
// output channel: out_valid/out_ready carries snapshot rows only, bids then asks,
//   2*SNAPSHOT_DEPTH rows per snapshot, last set on the final ask row
// the back end walks one level table in a single-port memory, reading a level
//   and then evaluating or writing it: add and delete scan the levels and then
//   shift the levels behind an insert or a removal; clear empties both tables
// a trade walks the opposite table from its best level and shifts out emptied levels
// a snapshot reads each row and then presents it once the output register is free
// reset empties both tables and clears the overflow flag; the level memory
//   needs no clearing pass
// when the receiver stalls the snapshot pauses with the row held, while the
//   queue keeps taking requests until it fills
module price_level_order_book
	import plob_pkg::*;
#(
	parameter int LEVELS         = PLOB_LEVELS,
	parameter int SNAPSHOT_DEPTH = PLOB_SNAPSHOT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] repl_price,
	input  logic [31:0] new_quantity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        book_side,
	output logic [3:0]  level_index,
	output logic [31:0] level_price,
	output logic [47:0] level_size,
	output logic [15:0] order_count,
	output logic        overflow,
	output logic        last
);

	`include "price_level_order_book_assert.svh"

	logic q_valid, q_ready;
	req_t q_req;

	plob_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.side         (side),
		.price        (price),
		.quantity     (quantity),
		.repl_price   (repl_price),
		.new_quantity (new_quantity),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_req        (q_req)
	);

	plob_back #(
		.LEVELS         (LEVELS),
		.SNAPSHOT_DEPTH (SNAPSHOT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_req       (q_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.book_side   (book_side),
		.level_index (level_index),
		.level_price (level_price),
		.level_size  (level_size),
		.order_count (order_count),
		.overflow    (overflow),
		.last        (last)
	);

	`PLOB_ASSERT_NOW(a_last_row, out_valid && last,
		book_side && (level_index == 4'(SNAPSHOT_DEPTH - 1)), "last on wrong row")
	`PLOB_ASSERT_NOW(a_overflow_sticky, 1'b1, !$fell(overflow), "overflow flag cleared")
	`PLOB_ASSERT_NEXT(a_modify_split,
		in_valid && in_ready && (command == CMD_MODIFY) && (new_quantity != '0),
		!in_ready, "modify not split")

endmodule
